// ===== rtl/lph_pkg.sv =====
// Shared types and constants of the linear-probing hash table.
// Depends on nothing; the home slot unit, the core and the testbench import it.
package lph_pkg;

   localparam int TABLE_SLOTS = 16;
   localparam int IDX_W       = $clog2(TABLE_SLOTS);
   localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

   localparam int ACTION_W = 2;
   localparam int KEY_W    = 31;
   localparam int SLOT_W   = 4;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_SEARCH = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] home;
   } mod_status_type;

   // Low SLOT_W bits of a slot index, zero-extended when the index is narrower.
   function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

endpackage

// ===== rtl/lph_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; no package needed.
module lph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lph_mod.sv =====
// Home slot unit: registers key modulo TABLE_SLOTS in the cycle after start.
// Depends on lph_pkg.
module lph_mod (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lph_pkg::KEY_W-1:0]  key,
   output lph_pkg::mod_status_type    status
);
   import lph_pkg::*;

   logic [IDX_W-1:0] rem_ff, rem_in;
   logic             done_ff, done_in;

   // TABLE_SLOTS is a power of two, so the modulo keeps the low key bits.
   always_comb begin
      rem_in  = rem_ff;
      done_in = start;
      if (start) begin
         rem_in = IDX_W'(key % KEY_W'(TABLE_SLOTS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   assign status.done = done_ff;
   assign status.home = rem_ff;

endmodule

// ===== rtl/linear_probe_hash_table_core.sv =====
// Linear-probing hash table core: insert, delete and search of 31-bit keys.
// Steps: home-slot select, then the probe walk, one slot at a time (lookups add the
// key RAM read latency), then a load into the output register. One request in
// flight: the next request is taken once the result has moved into the output
// register; the probe walk over the key RAM sets how long a request takes.
// Reset clears every occupancy bit at once; no clearing pass is needed.
module linear_probe_hash_table_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [lph_pkg::ACTION_W-1:0] req_action,
   input  logic [lph_pkg::KEY_W-1:0]    req_key,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_status,
   output logic [lph_pkg::SLOT_W-1:0]   rsp_slot
);
   import lph_pkg::*;

   // Control state.
   state_type              state_ff, state_in;
   logic [TABLE_SLOTS-1:0] used_ff, used_in;     // occupancy bit per slot
   logic                   pend_ff, pend_in;     // key read issued last cycle
   logic                   rsp_valid_ff, rsp_valid_in;

   // Request and walk payload.
   logic [ACTION_W-1:0]    action_ff, action_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;       // next slot to probe
   logic [CNT_W-1:0]       cnt_ff, cnt_in;       // slots probed or reads issued
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic                   res_ok_ff, res_ok_in;
   logic [IDX_W-1:0]       res_idx_ff, res_idx_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;

   // Home slot unit and key store.
   logic                   mod_start;
   mod_status_type         mod_stat;
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [KEY_W-1:0]       ram_rd_data;

   logic [IDX_W-1:0]       idx_next;
   logic                   key_hit;
   logic                   action_known;

   lph_mod u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .key    (req_key),
      .status (mod_stat)
   );

   // Keys live in RAM; occupancy lives in flip-flops so reset empties the table.
   lph_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (key_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // Advance the probe pointer, wrapping at the last slot.
   assign idx_next = (idx_ff == IDX_W'(TABLE_SLOTS - 1)) ? '0 : idx_ff + 1'b1;

   // Key returned by the RAM matches only if its slot is still occupied.
   assign key_hit = used_ff[pend_idx_ff] && (ram_rd_data == key_ff);

   assign action_known = (action_ff == ACT_INSERT) || (action_ff == ACT_DELETE)
                      || (action_ff == ACT_SEARCH);

   // Accept a new request only when idle; a pending result sits in the
   // output register and is delivered from there.
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      action_in     = action_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      pend_idx_in   = pend_idx_ff;
      res_ok_in     = res_ok_ff;
      res_idx_in    = res_idx_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      mod_start     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      // Drop the result once its transfer completes.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               action_in = req_action;
               key_in    = req_key;
               mod_start = 1'b1;
               state_in  = ST_HASH;
            end
         end

         ST_HASH: begin
            if (mod_stat.done) begin
               idx_in  = mod_stat.home;
               cnt_in  = '0;
               pend_in = 1'b0;
               if (action_known) begin
                  state_in = ST_PROBE;
               end else begin
                  // Unused action code: answer failure, touch nothing.
                  res_ok_in  = 1'b0;
                  res_idx_in = '0;
                  state_in   = ST_RESP;
               end
            end
         end

         ST_PROBE: begin
            if (action_ff == ACT_INSERT) begin
               // Insert needs only occupancy: one slot per cycle.
               if (!used_ff[idx_ff]) begin
                  used_in[idx_ff] = 1'b1;
                  ram_wr_en       = 1'b1;
                  res_ok_in       = 1'b1;
                  res_idx_in      = idx_ff;
                  state_in        = ST_RESP;
               end else if (cnt_ff == CNT_W'(TABLE_SLOTS - 1)) begin
                  res_ok_in  = 1'b0;
                  res_idx_in = '0;
                  state_in   = ST_RESP;
               end else begin
                  idx_in = idx_next;
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               // Lookup: issue one key read per cycle, check it the next.
               pend_in = 1'b0;
               if (pend_ff && key_hit) begin
                  if (action_ff == ACT_DELETE) begin
                     used_in[pend_idx_ff] = 1'b0;
                  end
                  res_ok_in  = 1'b1;
                  res_idx_in = pend_idx_ff;
                  state_in   = ST_RESP;
               end else if (cnt_ff == CNT_W'(TABLE_SLOTS)) begin
                  // Last read checked without a match.
                  res_ok_in  = 1'b0;
                  res_idx_in = '0;
                  state_in   = ST_RESP;
               end else begin
                  ram_rd_en   = 1'b1;
                  pend_in     = 1'b1;
                  pend_idx_in = idx_ff;
                  idx_in      = idx_next;
                  cnt_in      = cnt_ff + 1'b1;
               end
            end
         end

         ST_RESP: begin
            // Hold until the output register is free or being emptied.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_ok_ff ? STATUS_OK : STATUS_FAIL;
               rsp_slot_in   = slot_field(res_idx_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      pend_idx_ff   <= pend_idx_in;
      res_ok_ff     <= res_ok_in;
      res_idx_ff    <= res_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

endmodule

// ===== tb/sv/tb_linear_probe_hash_table_core.sv =====
// Self-checking testbench for linear_probe_hash_table_core: directed and random
// insert/delete/search traffic checked against a shadow copy of the table.
// Depends on lph_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_core;
   import lph_pkg::*;

   // Unused action code; the core must answer it with a failure.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // Settling allowance after a drain, with margin over the slowest single request.
   localparam int SETTLE_CYCLES = 2 * (TABLE_SLOTS + 4);
   localparam int DRAIN_LIMIT   = 4000;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_ITEMS  = 1480;
   localparam int POOL_SIZE     = 12;

   typedef struct packed {
      logic              status;
      logic [SLOT_W-1:0] slot;
   } table_answer_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action;
   logic [KEY_W-1:0]    req_key;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;

   // Shadow copy of the table, advanced once per accepted request.
   logic             shadow_used [TABLE_SLOTS];
   logic [KEY_W-1:0] shadow_key  [TABLE_SLOTS];

   table_answer_type pending_answers [$];
   int               answer_errors = 0;

   // Idle ceilings for each side; zero gives stretches with no idling.
   int               send_gap_max = 15;
   int               recv_gap_max = 15;
   // One-shot long hold-off for the receiver, consumed by its own process.
   int               recv_long_hold = 0;

   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   linear_probe_hash_table_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Safety net: end the run well past the slowest legal finish.
   initial begin
      #6_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Compute the answer of one request and apply its effect to the shadow table.
   // Insert takes the first empty slot from home; delete and search skip empty
   // slots and stop at the first used slot holding the key.
   function automatic table_answer_type probe_table(input logic [ACTION_W-1:0] action,
                                                    input logic [KEY_W-1:0]    key);
      table_answer_type ans;
      int               home;
      int               idx;
      int               hit;
      logic             found;
      home  = int'(key % TABLE_SLOTS);
      found = 1'b0;
      hit   = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         idx = (home + i) % TABLE_SLOTS;
         if (!found) begin
            if (action == ACT_INSERT) begin
               if (!shadow_used[idx]) begin
                  found = 1'b1;
                  hit   = idx;
               end
            end else if (shadow_used[idx] && shadow_key[idx] == key) begin
               found = 1'b1;
               hit   = idx;
            end
         end
      end
      // Unused action code never succeeds and touches nothing.
      if (action != ACT_INSERT && action != ACT_DELETE && action != ACT_SEARCH)
         found = 1'b0;
      if (found) begin
         if (action == ACT_INSERT) begin
            shadow_used[hit] = 1'b1;
            shadow_key[hit]  = key;
         end else if (action == ACT_DELETE) begin
            shadow_used[hit] = 1'b0;
         end
      end
      ans.status = found ? STATUS_OK : STATUS_FAIL;
      // Slot field carries only the low SLOT_W bits, and zero on failure.
      ans.slot   = found ? SLOT_W'(hit) : '0;
      return ans;
   endfunction

   // Offer one request after a random gap; hold the payload until the transfer.
   task automatic send_request(input logic [ACTION_W-1:0] action,
                               input logic [KEY_W-1:0]    key);
      int gap;
      gap = $urandom_range(send_gap_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= action;
      req_key    <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Transfer happened at this edge: record what the core must answer.
      pending_answers.push_back(probe_table(action, key));
   endtask

   // Drop valid, wait for every outstanding answer, then let the core settle.
   task automatic wait_for_drain();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (pending_answers.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_answers.size() != 0) begin
         $display("%0t ns: %0d expected answers never arrived", $time,
                  pending_answers.size());
         answer_errors++;
         pending_answers.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Receiver: stall a random number of cycles per answer, then take and check it.
   initial begin
      int               hold;
      int               taken;
      table_answer_type want;
      taken = 0;
      forever begin
         if (recv_long_hold > 0) begin
            hold           = recv_long_hold;
            recv_long_hold = 0;
         end else begin
            hold = $urandom_range(recv_gap_max, 0);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         taken++;
         // Change the receiver's idling style every so often.
         if (taken % 64 == 0)
            recv_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 15;
         if (pending_answers.size() == 0) begin
            $display("%0t ns: unexpected answer status %0b slot %0d", $time,
                     rsp_status, rsp_slot);
            answer_errors++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t ns: status mismatch, expected %0b, actual %0b", $time,
                        want.status, rsp_status);
               answer_errors++;
            end
            if (rsp_slot !== want.slot) begin
               $display("%0t ns: slot mismatch, expected %0d, actual %0d", $time,
                        want.slot, rsp_slot);
               answer_errors++;
            end
         end
      end
   end

   // Extremes, collisions, wrap-around, no-tombstone lookups and bad codes.
   task automatic test_directed();
      send_request(ACT_SEARCH, 31'd7);            // empty table: not found
      send_request(ACT_DELETE, 31'h7FFF_FFFF);    // empty table: not found
      send_request(ACT_UNUSED, 31'h7FFF_FFFF);    // unused code
      send_request(ACT_INSERT, 31'd0);            // home 0
      send_request(ACT_INSERT, 31'h7FFF_FFFF);    // home 15, largest key
      send_request(ACT_INSERT, 31'd16);           // collides with 0, lands on 1
      send_request(ACT_INSERT, 31'd31);           // home 15 taken, wraps past 0 and 1
      send_request(ACT_SEARCH, 31'd31);
      send_request(ACT_SEARCH, 31'h7FFF_FFFF);
      send_request(ACT_DELETE, 31'd0);            // clear slot 0, leave no tombstone
      send_request(ACT_SEARCH, 31'd16);           // still found across the hole
      send_request(ACT_SEARCH, 31'd0);            // gone
      send_request(ACT_SEARCH, 31'd32);           // same home, never stored
      send_request(ACT_INSERT, 31'd16);           // duplicate refills slot 0
      send_request(ACT_DELETE, 31'd16);           // first match from home
      send_request(ACT_SEARCH, 31'd16);           // second copy remains
      send_request(ACT_UNUSED, 31'd16);           // unused code on a stored key
      send_request(ACT_SEARCH, 31'h5555_5555);
      send_request(ACT_INSERT, 31'h2AAA_AAAA);
      send_request(ACT_SEARCH, 31'h2AAA_AAAA);
      wait_for_drain();
   endtask

   // Fill every slot from one home, overflow it, then empty the table again.
   task automatic test_table_full();
      for (int i = 1; i <= TABLE_SLOTS + 1; i++)
         send_request(ACT_INSERT, KEY_W'((i << 4) | 5));
      send_request(ACT_SEARCH, 31'h7FFF_FFF5);    // full walk without a match
      send_request(ACT_DELETE, 31'h7FFF_FFF5);
      send_request(ACT_SEARCH, 31'd85);
      wait_for_drain();
      for (int s = 0; s < TABLE_SLOTS; s++)
         while (shadow_used[s]) send_request(ACT_DELETE, shadow_key[s]);
      wait_for_drain();
   endtask

   // Hold the receiver off for a long stretch while requests keep coming.
   task automatic test_back_pressure();
      send_gap_max   = 0;
      recv_long_hold = LONG_HOLD;
      for (int i = 0; i < 12; i++)
         send_request(i % 3 == 0 ? ACT_INSERT : ACT_SEARCH, KEY_W'(i * 16 + 3));
      send_gap_max = 15;
      wait_for_drain();
   endtask

   // Draw a fresh set of keys, about half crowding onto three adjacent home slots.
   task automatic refresh_key_pool();
      logic [3:0] base;
      base = 4'($urandom);
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = KEY_W'($urandom);
         if ($urandom_range(1, 0) == 1)
            key_pool[i][3:0] = base + 4'($urandom_range(2, 0));
      end
   endtask

   // Pick a key currently held in the table, or the fallback if it is empty.
   function automatic logic [KEY_W-1:0] stored_key_or(input logic [KEY_W-1:0] fallback);
      int start;
      int idx;
      start = $urandom_range(TABLE_SLOTS - 1, 0);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         idx = (start + i) % TABLE_SLOTS;
         if (shadow_used[idx]) return shadow_key[idx];
      end
      return fallback;
   endfunction

   // Mostly clustered pool keys and stored keys, some fully random noise.
   task automatic test_random();
      int                  pick;
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    key;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            refresh_key_pool();
            send_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 15;
         end
         // Pause the sender until everything has come back now and then.
         if (n % 250 == 249) wait_for_drain();
         pick = $urandom_range(99, 0);
         if (pick < 35)      action = ACT_INSERT;
         else if (pick < 65) action = ACT_DELETE;
         else if (pick < 95) action = ACT_SEARCH;
         else                action = ACT_UNUSED;
         if ($urandom_range(99, 0) < 15)
            key = KEY_W'($urandom);
         else
            key = key_pool[$urandom_range(POOL_SIZE - 1, 0)];
         if (action != ACT_INSERT && $urandom_range(1, 0) == 1)
            key = stored_key_or(key);
         send_request(action, key);
      end
      wait_for_drain();
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_action = ACT_INSERT;
      req_key    = '0;
      for (int s = 0; s < TABLE_SLOTS; s++) begin
         shadow_used[s] = 1'b0;
         shadow_key[s]  = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_table_full();
      test_back_pressure();
      test_random();

      if (answer_errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lph_pkg.sv
rtl/lph_ram.sv
rtl/lph_mod.sv
rtl/linear_probe_hash_table_core.sv
tb/sv/tb_linear_probe_hash_table_core.sv
